@@ src/dlsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dlsp_pkg
// Shared widths, register indexes, controller states, datapath commands and
// the fixed-point log helpers of the dual-axis log speed profile.
// ----------------------------------------------------------------------------
package dlsp_pkg;

	localparam int POS_W      = 20;
	localparam int LFB        = 8;
	localparam int MANT_BITS  = 30;
	localparam int SPAN_W     = 16;
	localparam int SPD_W      = 7;
	localparam int DRIVE_W    = SPD_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SPAN_W;

	// widest value whose log is taken: |e|+1 or span+1
	localparam int LOD_W        = (POS_W + 1 > SPAN_W + 1) ? POS_W + 1 : SPAN_W + 1;
	localparam int K_W          = $clog2(LOD_W);
	localparam int LOG_W        = K_W + LFB;
	localparam int PROD_W       = LOG_W + SPD_W;
	localparam int STEP_W       = $clog2(SPD_W);
	localparam int FRAC_ENTRIES = 1 << LFB;

	localparam logic [POS_W-1:0]  POS_MAX         = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0]  POS_MIN         = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic [SPD_W-1:0]  MAX_SPEED_RST   = {SPD_W{1'b1}};
	localparam logic [SPAN_W-1:0] LOG_SPAN_RST    = SPAN_W'(750);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_SPEED      = 2'd0,
		REG_LEFT_LOG_SPAN  = 2'd1,
		REG_RIGHT_LOG_SPAN = 2'd2,
		REG_ABSOLUTE_MODE  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LATCH,
		ST_ERROR,
		ST_MAGN,
		ST_NORM,
		ST_LOOKUP,
		ST_SCALE,
		ST_DIV_INIT,
		ST_DIVIDE,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic latch;
		logic error;
		logic magn;
		logic norm;
		logic lookup;
		logic scale;
		logic div_init;
		logic div_step;
		logic result;
	} dp_cmd_t;

	typedef struct packed {
		logic [K_W-1:0] k;
		logic [LFB-1:0] idx;
	} log_norm_t;

	typedef logic [FRAC_ENTRIES-1:0][LFB-1:0] frac_tab_t;

	// fraction of log2(1 + i/2^LFB), digit by digit: square, emit a bit when >= 2
	function automatic frac_tab_t build_frac_table();
		frac_tab_t      t;
		logic [63:0]    m;
		logic [63:0]    two;
		logic [LFB-1:0] r;
		two = 64'd2 << MANT_BITS;
		for (int idx = 0; idx < FRAC_ENTRIES; idx++) begin
			m = ((64'd1 << LFB) + 64'(idx)) << (MANT_BITS - LFB);
			r = '0;
			for (int i = 0; i < LFB; i++) begin
				m = (m * m) >> MANT_BITS;
				r = r << 1;
				if (m >= two) begin
					r[0] = 1'b1;
					m    = m >> 1;
				end
			end
			t[idx] = r;
		end
		return t;
	endfunction

	localparam frac_tab_t FRAC_TABLE = build_frac_table();

	// leading-one position and the LFB bits right below it (x is never zero)
	function automatic log_norm_t log_norm(input logic [LOD_W-1:0] x);
		log_norm_t      r;
		logic [LOD_W-1:0] norm;
		logic [K_W-1:0] sh;
		r.k = '0;
		for (int i = 0; i < LOD_W; i++) begin
			if (x[i]) r.k = K_W'(i);
		end
		sh    = K_W'(LOD_W - 1) - r.k;
		norm  = x << sh;
		r.idx = norm[LOD_W-2 -: LFB];
		return r;
	endfunction

endpackage

@@ src/dlsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlsp_ctrl
// Sequencer: walks one word through latch, error, log, scale and divide
// steps, and owns the valid bit of the result register.
// ----------------------------------------------------------------------------
module dlsp_ctrl import dlsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	ctrl_state_t       state_q;
	ctrl_state_t       state_nxt;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              last_step;
	logic              slot_free;

	assign last_step = (step_q == STEP_W'(SPD_W - 1));
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_nxt = ST_LATCH;
			ST_LATCH:    state_nxt = ST_ERROR;
			ST_ERROR:    state_nxt = ST_MAGN;
			ST_MAGN:     state_nxt = ST_NORM;
			ST_NORM:     state_nxt = ST_LOOKUP;
			ST_LOOKUP:   state_nxt = ST_SCALE;
			ST_SCALE:    state_nxt = ST_DIV_INIT;
			ST_DIV_INIT: state_nxt = ST_DIVIDE;
			ST_DIVIDE:   if (last_step) state_nxt = ST_FINISH;
			ST_FINISH:   if (slot_free) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_LATCH:    cmd.latch    = 1'b1;
			ST_ERROR:    cmd.error    = 1'b1;
			ST_MAGN:     cmd.magn     = 1'b1;
			ST_NORM:     cmd.norm     = 1'b1;
			ST_LOOKUP:   cmd.lookup   = 1'b1;
			ST_SCALE:    cmd.scale    = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIVIDE:   cmd.div_step = 1'b1;
			ST_FINISH:   cmd.result   = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_init) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			// load the result register, or drop the word once taken
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/dlsp_datapath.sv @@
// ----------------------------------------------------------------------------
// dlsp_datapath
// Configuration registers, reference latch, error and magnitude, fixed-point
// log, scale by full speed and a two-lane restoring divider, result register.
// ----------------------------------------------------------------------------
module dlsp_datapath import dlsp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic signed [POS_W-1:0]   left_goal,
	input  logic signed [POS_W-1:0]   right_goal,
	input  logic signed [POS_W-1:0]   left_position,
	input  logic signed [POS_W-1:0]   right_position,
	input  logic                      restart,
	output logic signed [DRIVE_W-1:0] left_drive,
	output logic signed [DRIVE_W-1:0] right_drive,
	output logic [POS_W-1:0]          remaining_error
);

	// configuration
	logic [SPD_W-1:0]  max_speed_q;
	logic [SPAN_W-1:0] left_span_q;
	logic [SPAN_W-1:0] right_span_q;
	logic              absolute_q;

	// per-side working registers, index 0 left, 1 right
	logic [POS_W-1:0]  goal_q  [2];
	logic [POS_W-1:0]  pos_q   [2];
	logic [POS_W-1:0]  ref_q   [2];
	logic [POS_W:0]    err_q   [2];
	logic [POS_W-1:0]  mag_q   [2];
	logic [LOD_W-1:0]  spanx_q [2];
	log_norm_t         ne_q    [2];
	log_norm_t         ns_q    [2];
	logic [LOG_W-1:0]  le_q    [2];
	logic [LOG_W-1:0]  ls_q    [2];
	logic [PROD_W-1:0] num_q   [2];
	logic [PROD_W-1:0] rem_q   [2];
	logic [PROD_W-1:0] dvs_q   [2];
	logic [SPD_W-1:0]  quo_q   [2];
	logic              ovf_q   [2];
	logic              restart_q;
	logic              latched_q;

	logic [POS_W-1:0]   drive_lq;
	logic [POS_W-1:0]   rem_err_q;
	logic [DRIVE_W-1:0] drive_q [2];

	// combinational per side
	logic [POS_W:0]     sum     [2];
	logic [POS_W-1:0]   sat     [2];
	logic [POS_W:0]     absv    [2];
	logic [SPAN_W-1:0]  span    [2];
	logic [SPD_W-1:0]   speed   [2];
	logic [DRIVE_W-1:0] drive   [2];
	logic [POS_W-1:0]   biggest;

	assign span[0] = left_span_q;
	assign span[1] = right_span_q;

	always_comb begin
		for (int s = 0; s < 2; s++) begin
			sum[s] = {goal_q[s][POS_W-1], goal_q[s]} + {pos_q[s][POS_W-1], pos_q[s]};
			if (sum[s][POS_W] != sum[s][POS_W-1]) begin
				sat[s] = sum[s][POS_W] ? POS_MIN : POS_MAX;
			end else begin
				sat[s] = sum[s][POS_W-1:0];
			end
			absv[s] = err_q[s][POS_W] ? (~err_q[s] + 1'b1) : err_q[s];
			if (ovf_q[s] || (quo_q[s] > max_speed_q)) begin
				speed[s] = max_speed_q;
			end else begin
				speed[s] = quo_q[s];
			end
			drive[s] = err_q[s][POS_W] ? (~{1'b0, speed[s]} + 1'b1) : {1'b0, speed[s]};
		end
		biggest = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= MAX_SPEED_RST;
			left_span_q  <= LOG_SPAN_RST;
			right_span_q <= LOG_SPAN_RST;
			absolute_q   <= 1'b0;
			ref_q[0]     <= '0;
			ref_q[1]     <= '0;
			latched_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MAX_SPEED:      max_speed_q  <= cfg_data[SPD_W-1:0];
					REG_LEFT_LOG_SPAN:  left_span_q  <= cfg_data[SPAN_W-1:0];
					REG_RIGHT_LOG_SPAN: right_span_q <= cfg_data[SPAN_W-1:0];
					REG_ABSOLUTE_MODE:  absolute_q   <= cfg_data[0];
					default: ;
				endcase
			end
			// take new references on the first word after reset or a restart
			if (cmd.latch && (restart_q || !latched_q)) begin
				for (int s = 0; s < 2; s++) begin
					ref_q[s] <= absolute_q ? goal_q[s] : sat[s];
				end
				latched_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			goal_q[0] <= left_goal;
			goal_q[1] <= right_goal;
			pos_q[0]  <= left_position;
			pos_q[1]  <= right_position;
			restart_q <= restart;
		end
		for (int s = 0; s < 2; s++) begin
			if (cmd.error) begin
				err_q[s] <= {ref_q[s][POS_W-1], ref_q[s]} - {pos_q[s][POS_W-1], pos_q[s]};
			end
			if (cmd.magn) begin
				mag_q[s]   <= absv[s][POS_W-1:0];
				spanx_q[s] <= ((span[s] == '0) ? LOD_W'(1) : LOD_W'(span[s])) + LOD_W'(1);
			end
			if (cmd.norm) begin
				ne_q[s] <= log_norm(LOD_W'(mag_q[s]) + LOD_W'(1));
				ns_q[s] <= log_norm(spanx_q[s]);
			end
			if (cmd.lookup) begin
				le_q[s] <= {ne_q[s].k, FRAC_TABLE[ne_q[s].idx]};
				ls_q[s] <= {ns_q[s].k, FRAC_TABLE[ns_q[s].idx]};
			end
			if (cmd.scale) begin
				// full speed is 2^SPD_W - 1
				num_q[s] <= {le_q[s], SPD_W'(0)} - PROD_W'(le_q[s]);
			end
			if (cmd.div_init) begin
				ovf_q[s] <= (num_q[s] >= {ls_q[s], SPD_W'(0)});
				rem_q[s] <= num_q[s];
				dvs_q[s] <= PROD_W'({ls_q[s], (SPD_W-1)'(0)});
				quo_q[s] <= '0;
			end else if (cmd.div_step) begin
				if (rem_q[s] >= dvs_q[s]) begin
					rem_q[s] <= rem_q[s] - dvs_q[s];
					quo_q[s] <= {quo_q[s][SPD_W-2:0], 1'b1};
				end else begin
					quo_q[s] <= {quo_q[s][SPD_W-2:0], 1'b0};
				end
				dvs_q[s] <= dvs_q[s] >> 1;
			end
			if (cmd.result) begin
				drive_q[s] <= drive[s];
			end
		end
		if (cmd.result) begin
			rem_err_q <= biggest;
		end
	end

	assign drive_lq        = rem_err_q;
	assign left_drive      = drive_q[0];
	assign right_drive     = drive_q[1];
	assign remaining_error = drive_lq;

endmodule

@@ src/dual_axis_log_speed_profile.sv @@
// ----------------------------------------------------------------------------
// dual_axis_log_speed_profile
// Two-sided drive command with logarithmic speed versus remaining error.
// ----------------------------------------------------------------------------
// Each accepted word passes the latch, error, magnitude, log and scale steps and then
// the seven-step restoring divider before it reaches the result register; one item
// in flight at a time.
// A finished result waits in its register while the next word is taken.
// Reset: references cleared and unlatched, registers to their reset values,
// result register empty.
module dual_axis_log_speed_profile import dlsp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [POS_W-1:0]   left_goal,
	input  logic signed [POS_W-1:0]   right_goal,
	input  logic signed [POS_W-1:0]   left_position,
	input  logic signed [POS_W-1:0]   right_position,
	input  logic                      restart,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DRIVE_W-1:0] left_drive,
	output logic signed [DRIVE_W-1:0] right_drive,
	output logic [POS_W-1:0]          remaining_error,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	dlsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	dlsp_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.left_goal       (left_goal),
		.right_goal      (right_goal),
		.left_position   (left_position),
		.right_position  (right_position),
		.restart         (restart),
		.left_drive      (left_drive),
		.right_drive     (right_drive),
		.remaining_error (remaining_error)
	);

endmodule

@@ src/dlsp_checker.sv @@
// ----------------------------------------------------------------------------
// dlsp_checker
// Port-level checks on the speed profile block, bound to the top level.
// ----------------------------------------------------------------------------
module dlsp_checker import dlsp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [DRIVE_W-1:0] left_drive,
	input logic signed [DRIVE_W-1:0] right_drive,
	input logic [POS_W-1:0]          remaining_error
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_drive)
			&& $stable(right_drive) && $stable(remaining_error))
		else $error("result word changed while stalled");

	// one word in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	// drive magnitude never exceeds full speed
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_drive != {1'b1, {SPD_W{1'b0}}}
			&& right_drive != {1'b1, {SPD_W{1'b0}}})
		else $error("drive out of range");

	// no error left on either side means both drives stop
	a_zero_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && remaining_error == '0 |-> left_drive == '0 && right_drive == '0)
		else $error("drive without remaining error");

endmodule

bind dual_axis_log_speed_profile dlsp_checker u_checker (.*);

@@ dv/dual_axis_log_speed_profile_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_axis_log_speed_profile_tb
// Drives position words through the log speed profile and checks every drive
// command against a local model: reference latching, saturating error, the
// fixed-point log ratio, the speed clamp and the sign of the error.
// ----------------------------------------------------------------------------
module dual_axis_log_speed_profile_tb;
	import dlsp_pkg::*;

	localparam int          FULL_SCALE    = 127;
	localparam int          MANT          = 30;
	localparam int          SETTLE_CYCLES = 24;
	localparam int          CYCLE_LIMIT   = 500000;
	localparam int          RANDOM_PHASES = 8;
	localparam int          PHASE_WORDS   = 125;
	localparam longint      ERR_LIMIT     = (64'd1 << POS_W) - 1;

	typedef struct packed {
		logic signed [POS_W-1:0] left_goal;
		logic signed [POS_W-1:0] right_goal;
		logic signed [POS_W-1:0] left_pos;
		logic signed [POS_W-1:0] right_pos;
		logic                    restart;
	} motion_word_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] left_drive;
		logic signed [DRIVE_W-1:0] right_drive;
		logic [POS_W-1:0]          remaining;
	} drive_cmd_t;

	logic                      clk             = 1'b0;
	logic                      arst_n          = 1'b0;
	logic                      in_valid        = 1'b0;
	logic                      in_ready;
	logic signed [POS_W-1:0]   left_goal       = '0;
	logic signed [POS_W-1:0]   right_goal      = '0;
	logic signed [POS_W-1:0]   left_position   = '0;
	logic signed [POS_W-1:0]   right_position  = '0;
	logic                      restart         = 1'b0;
	logic                      out_valid;
	logic                      out_ready       = 1'b0;
	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;
	logic [POS_W-1:0]          remaining_error;
	logic                      cfg_valid       = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index       = '0;
	logic [CFG_DATA_W-1:0]     cfg_data        = '0;

	// register mirror and latched references of the local model
	logic [SPD_W-1:0]  top_speed;
	logic [SPAN_W-1:0] span_left;
	logic [SPAN_W-1:0] span_right;
	logic              abs_mode;
	longint            ref_left;
	longint            ref_right;
	bit                refs_held;
	logic [LFB-1:0]    log_frac [FRAC_ENTRIES];

	motion_word_t word_q [$];
	drive_cmd_t   cmd_q [$];
	motion_word_t cur_word;
	drive_cmd_t   seen_cmd;
	drive_cmd_t   want_cmd;
	int           burst_left;
	int           gap_left;
	logic [15:0]  stall_mask;
	logic [3:0]   stall_pos;
	int           fault_count = 0;
	int           cycle_count = 0;

	dual_axis_log_speed_profile dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.left_goal       (left_goal),
		.right_goal      (right_goal),
		.left_position   (left_position),
		.right_position  (right_position),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.left_drive      (left_drive),
		.right_drive     (right_drive),
		.remaining_error (remaining_error),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// log2 fraction of 1 + j/2^LFB: square the mantissa, emit a one each time it reaches 2
	function automatic void fill_log_fractions();
		longint unsigned m;
		longint unsigned two;
		logic [LFB-1:0]  bits;
		two = 64'd2 << MANT;
		for (int j = 0; j < FRAC_ENTRIES; j++) begin
			m    = longint'(FRAC_ENTRIES + j) << (MANT - LFB);
			bits = '0;
			for (int s = 0; s < LFB; s++) begin
				m    = (m * m) >> MANT;
				bits = {bits[LFB-2:0], m >= two};
				if (m >= two) m = m >> 1;
			end
			log_frac[j] = bits;
		end
	endfunction

	function automatic int unsigned log2_fixed(input int unsigned x);
		int unsigned msb;
		int unsigned rem;
		int unsigned idx;
		msb = 0;
		for (int b = 0; b < 32; b++) begin
			if (x[b]) msb = b;
		end
		rem = x - (32'd1 << msb);
		idx = (msb >= LFB) ? rem >> (msb - LFB) : rem << (LFB - msb);
		return (msb << LFB) + log_frac[idx & (FRAC_ENTRIES - 1)];
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
		if (v > longint'($signed(POS_MAX))) return POS_MAX;
		if (v < longint'($signed(POS_MIN))) return POS_MIN;
		return v[POS_W-1:0];
	endfunction

	function automatic logic [DRIVE_W-1:0] side_drive(input longint err, input longint mag,
			input logic [SPAN_W-1:0] span);
		int unsigned    s;
		int unsigned    spd;
		logic [DRIVE_W-1:0] d;
		s   = (span == 0) ? 1 : span;
		spd = (FULL_SCALE * log2_fixed(int'(mag) + 1)) / log2_fixed(s + 1);
		if (spd > top_speed) spd = top_speed;
		d = spd[DRIVE_W-1:0];
		if (err < 0) d = -d;
		return d;
	endfunction

	// one drive command per accepted word; latches references as the block does
	function automatic drive_cmd_t speed_profile(input motion_word_t w);
		drive_cmd_t c;
		longint     err_l;
		longint     err_r;
		longint     mag_l;
		longint     mag_r;
		if (w.restart) refs_held = 1'b0;
		if (!refs_held) begin
			if (abs_mode) begin
				ref_left  = w.left_goal;
				ref_right = w.right_goal;
			end else begin
				ref_left  = clamp_pos(longint'(w.left_goal) + w.left_pos);
				ref_right = clamp_pos(longint'(w.right_goal) + w.right_pos);
			end
			refs_held = 1'b1;
		end
		err_l = ref_left - w.left_pos;
		err_r = ref_right - w.right_pos;
		mag_l = (err_l < 0) ? -err_l : err_l;
		mag_r = (err_r < 0) ? -err_r : err_r;
		if (mag_l > ERR_LIMIT) mag_l = ERR_LIMIT;
		if (mag_r > ERR_LIMIT) mag_r = ERR_LIMIT;
		c.left_drive  = side_drive(err_l, mag_l, span_left);
		c.right_drive = side_drive(err_r, mag_r, span_right);
		c.remaining   = (mag_l > mag_r) ? mag_l[POS_W-1:0] : mag_r[POS_W-1:0];
		return c;
	endfunction

	function automatic logic signed [POS_W-1:0] rand_pos();
		case ($urandom_range(0, 9))
			0: return POS_MAX;
			1: return POS_MIN;
			2: return '0;
			3: return POS_W'($urandom_range(0, 1000)) - POS_W'(500);
			default: return POS_W'($urandom);
		endcase
	endfunction

	// error offsets of every magnitude, from zero to the full range
	function automatic longint rand_offset();
		int     w;
		longint v;
		w = $urandom_range(0, POS_W);
		v = longint'({$urandom, $urandom}) & ((64'd1 << w) - 1);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	task automatic push_word(input logic signed [POS_W-1:0] lg, input logic signed [POS_W-1:0] rg,
			input logic signed [POS_W-1:0] lp, input logic signed [POS_W-1:0] rp,
			input logic rs);
		motion_word_t w;
		w.left_goal  = lg;
		w.right_goal = rg;
		w.left_pos   = lp;
		w.right_pos  = rp;
		w.restart    = rs;
		word_q.push_back(w);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MAX_SPEED:      top_speed  = data[SPD_W-1:0];
			REG_LEFT_LOG_SPAN:  span_left  = data[SPAN_W-1:0];
			REG_RIGHT_LOG_SPAN: span_right = data[SPAN_W-1:0];
			REG_ABSOLUTE_MODE:  abs_mode   = data[0];
			default: ;
		endcase
	endtask

	// narrow registers get junk in the unused upper bits
	task automatic set_profile(input int ms, input int sl, input int sr, input int am);
		write_reg(REG_MAX_SPEED, (16'($urandom) & ~16'h007F) | 16'(ms));
		write_reg(REG_LEFT_LOG_SPAN, 16'(sl));
		write_reg(REG_RIGHT_LOG_SPAN, 16'(sr));
		write_reg(REG_ABSOLUTE_MODE, (16'($urandom) & ~16'h0001) | 16'(am));
	endtask

	function automatic int pick_span();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 65535;
			3: return 750;
			4, 5: return $urandom_range(2, 64);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic int pick_speed();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 127;
			2: return 1;
			default: return $urandom_range(0, 127);
		endcase
	endfunction

	// mostly restart-then-approach runs; the rest is unconstrained noise
	task automatic queue_random(input int n);
		int                      queued;
		int                      run;
		logic signed [POS_W-1:0] g_l;
		logic signed [POS_W-1:0] g_r;
		logic signed [POS_W-1:0] p_l;
		logic signed [POS_W-1:0] p_r;
		longint                  aim_l;
		longint                  aim_r;
		queued = 0;
		while (queued < n) begin
			if ($urandom_range(0, 3) == 0) begin
				push_word(POS_W'($urandom), POS_W'($urandom), rand_pos(), rand_pos(),
					1'($urandom_range(0, 1)));
				queued++;
			end else begin
				g_l = rand_pos();
				g_r = rand_pos();
				p_l = rand_pos();
				p_r = rand_pos();
				push_word(g_l, g_r, p_l, p_r, 1'b1);
				queued++;
				aim_l = abs_mode ? longint'(g_l) : clamp_pos(longint'(g_l) + p_l);
				aim_r = abs_mode ? longint'(g_r) : clamp_pos(longint'(g_r) + p_r);
				run   = $urandom_range(1, 15);
				for (int i = 0; i < run && queued < n; i++) begin
					push_word(POS_W'($urandom), POS_W'($urandom),
						clamp_pos(aim_l - rand_offset()), clamp_pos(aim_r - rand_offset()), 1'b0);
					queued++;
				end
			end
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (word_q.size() != 0 || in_valid || cmd_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// driver: bursts of words with random gaps in between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid       <= 1'b0;
			left_goal      <= '0;
			right_goal     <= '0;
			left_position  <= '0;
			right_position <= '0;
			restart        <= 1'b0;
			burst_left     = 0;
			gap_left       = 0;
		end else begin
			if (in_valid && in_ready) cmd_q.push_back(speed_profile(cur_word));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (word_q.size() > 0) begin
					cur_word       = word_q.pop_front();
					left_goal      <= cur_word.left_goal;
					right_goal     <= cur_word.right_goal;
					left_position  <= cur_word.left_pos;
					right_position <= cur_word.right_pos;
					restart        <= cur_word.restart;
					in_valid       <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted word, stall on a 16-bit ready mask re-drawn every lap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_mask = 16'hFFFF;
			stall_pos  = '0;
		end else begin
			if (out_valid && out_ready) begin
				seen_cmd.left_drive  = left_drive;
				seen_cmd.right_drive = right_drive;
				seen_cmd.remaining   = remaining_error;
				if (cmd_q.size() == 0) begin
					if (fault_count < 10)
						$display("[%0t] unexpected word: L=%0d R=%0d err=%0d", $time,
							$signed(seen_cmd.left_drive), $signed(seen_cmd.right_drive),
							seen_cmd.remaining);
					fault_count++;
				end else begin
					want_cmd = cmd_q.pop_front();
					if (seen_cmd !== want_cmd) begin
						if (fault_count < 10) begin
							$display("[%0t] drive mismatch: expected L=%0d R=%0d err=%0d",
								$time, $signed(want_cmd.left_drive),
								$signed(want_cmd.right_drive), want_cmd.remaining);
							$display("[%0t] drive mismatch: got L=%0d R=%0d err=%0d",
								$time, $signed(seen_cmd.left_drive),
								$signed(seen_cmd.right_drive), seen_cmd.remaining);
						end
						fault_count++;
					end
				end
			end
			stall_pos = stall_pos + 1'b1;
			if (stall_pos == 0) begin
				case ($urandom_range(0, 7))
					0, 1, 2: stall_mask = 16'hFFFF;
					3:       stall_mask = 16'h0001 << $urandom_range(0, 15);
					default: stall_mask = 16'($urandom);
				endcase
			end
			out_ready <= stall_mask[stall_pos];
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		fill_log_fractions();
		top_speed  = MAX_SPEED_RST;
		span_left  = LOG_SPAN_RST;
		span_right = LOG_SPAN_RST;
		abs_mode   = 1'b0;
		ref_left   = 0;
		ref_right  = 0;
		refs_held  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: first word latches without a restart
		push_word(5, -7, 0, 0, 1'b0);
		push_word(999, 3, 4, -6, 1'b0);
		push_word(0, 0, 5, -7, 1'b0);
		push_word(750, -750, 0, 0, 1'b1);
		push_word(0, 0, 1, -1, 1'b0);
		push_word(0, 0, -1, 1, 1'b0);
		push_word(POS_MAX, POS_MIN, POS_MAX, POS_MIN, 1'b1);
		push_word(0, 0, POS_MIN, POS_MAX, 1'b0);
		push_word(POS_MIN, POS_MAX, -1, 1, 1'b1);
		push_word(-1, -1, -1, -1, 1'b1);
		push_word(12345, -54321, -2222, 3333, 1'b1);
		wait_idle();

		// absolute targets with the narrowest and widest spans
		set_profile(127, 1, 65535, 1);
		push_word(1, 65535, 0, 0, 1'b1);
		push_word(7, 7, 2, 32768, 1'b0);
		push_word(POS_MAX, POS_MIN, POS_MIN, POS_MAX, 1'b1);
		push_word(0, 0, 0, 0, 1'b0);
		push_word(0, 0, 0, 0, 1'b1);
		wait_idle();

		// zero clamp and zero spans
		set_profile(0, 0, 0, 0);
		push_word(100, -100, 0, 0, 1'b1);
		push_word(0, 0, 50, -50, 1'b0);
		wait_idle();

		set_profile(1, 2, 3, 0);
		push_word(0, 0, 49, 0, 1'b0);
		push_word(0, 3, 0, 0, 1'b1);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_profile(pick_speed(), pick_span(), pick_span(), $urandom_range(0, 1));
			queue_random(PHASE_WORDS);
			wait_idle();
		end

		if (fault_count == 0 && cmd_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
